FILE: design/fcsl_pkg.sv
package fcsl_pkg;

   localparam int NUM_VOICES = 8;
   localparam int VOICE_W    = 3;
   localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CUT_W      = 16;
   localparam int TYPE_W     = 2;
   localparam int RATE_W     = 8;
   localparam int CNT_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CUT_W-1:0] CUTOFF_MAX = 16'd15000;
   localparam logic [CNT_W:0]   LFO_SPAN   = 11'd512;

   localparam int MUL_W    = 10;
   localparam int DIV_BITS = CUT_W + MUL_W;
   localparam int DVS_W    = 11;
   localparam int DCNT_W   = $clog2(DIV_BITS);
   localparam logic [MUL_W-1:0] SWEEP_MUL  = 10'd1000;
   localparam logic [DVS_W-1:0] SWEEP_BASE = 11'd1010;

   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_START  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_TARGET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_RATE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LFO_RATE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LFO_DEPTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_TYPE  = 3'd5;

   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [VOICE_W-1:0] voice;
      logic               env_active;
   } req_type;

   typedef struct packed {
      logic [VOICE_W-1:0] voice_out;
      logic [CUT_W-1:0]   cutoff;
      logic [TYPE_W-1:0]  type_out;
      logic               apply;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic div_step;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic div_go;
      logic div_last;
   } status_type;

endpackage

FILE: design/filter_cutoff_sweep_lfo_core.sv
// Per-voice filter cutoff modulator. Pulse start with a request word while busy
// is low; exactly one result word follows on rsp with rsp_valid high for a
// single cycle, and the receiver cannot stall it, so it must take it then.
// A restart, an inactive tick, or a tick that needs no downward sweep goes
// from fetch straight to update and report; a tick with a downward sweep
// first runs the cutoff*1000/(1010+rate) quotient through a radix-2 serial
// divider, one bit per cycle over 26 bits, before update. Write the
// csr registers only while busy is low.
module filter_cutoff_sweep_lfo_core
   import fcsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req,
   output logic                  rsp_valid,
   output rsp_type               rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   fcsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   fcsl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

FILE: design/fcsl_ctrl.sv
module fcsl_ctrl
   import fcsl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FETCH  = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = status.div_go ? ST_DIVIDE : ST_UPDATE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_REPORT);
   assign cmd.accept    = start && (state_ff == ST_IDLE);
   assign cmd.fetch     = (state_ff == ST_FETCH);
   assign cmd.div_step  = (state_ff == ST_DIVIDE);
   assign cmd.update    = (state_ff == ST_UPDATE);

   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == ST_FETCH)
      else $error("accepted word did not enter fetch");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_update_report: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |=> rsp_valid)
      else $error("update not followed by result");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !rsp_valid && !cmd.fetch && !cmd.update)
      else $error("accept while working");

endmodule

FILE: design/fcsl_datapath.sv
module fcsl_datapath
   import fcsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  req_type               req,
   output rsp_type               rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CUT_W-1:0]  sweep_start_ff, sweep_target_ff;
   logic [RATE_W-1:0] sweep_rate_ff, lfo_rate_ff, lfo_depth_ff;
   logic [TYPE_W-1:0] filter_type_ff;

   logic [CUT_W-1:0] cutoff_ff [NUM_VOICES];
   logic [CNT_W-1:0] count_ff  [NUM_VOICES];
   logic             down_ff   [NUM_VOICES];

   req_type             req_ff;
   logic [CUT_W-1:0]    work_ff, work_in;
   logic                div_used_ff, div_used_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0]    rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   rsp_type             rsp_ff, rsp_in;

   logic [VIDX_W-1:0] idx;
   logic              voice_ok, tick, down_mode;
   logic [CUT_W-1:0]  c_rd;
   logic [CUT_W:0]    c_add;
   logic [CUT_W-1:0]  c_up;
   logic [DVS_W:0]    rem_sh;
   logic              q_bit;

   logic [CUT_W-1:0]  c_sw, c_lfo, c_new, c_out;
   logic [1:0]        step;
   logic [CUT_W:0]    c_step_up;
   logic [CNT_W-1:0]  cnt_inc;
   logic [CNT_W+RATE_W-1:0] cnt_prod;
   logic              lfo_on, flip;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_start_ff  <= '0;
         sweep_target_ff <= '0;
         sweep_rate_ff   <= '0;
         lfo_rate_ff     <= '0;
         lfo_depth_ff    <= '0;
         filter_type_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SWEEP_START:  sweep_start_ff  <= csr_wdata;
            CSR_SWEEP_TARGET: sweep_target_ff <= csr_wdata;
            CSR_SWEEP_RATE:   sweep_rate_ff   <= csr_wdata[RATE_W-1:0];
            CSR_LFO_RATE:     lfo_rate_ff     <= csr_wdata[RATE_W-1:0];
            CSR_LFO_DEPTH:    lfo_depth_ff    <= csr_wdata[RATE_W-1:0];
            CSR_FILTER_TYPE:  filter_type_ff  <= csr_wdata[TYPE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req;
   end

   assign idx       = req_ff.voice[VIDX_W-1:0];
   assign voice_ok  = int'(req_ff.voice) < NUM_VOICES;
   assign tick      = voice_ok && (req_ff.kind == KIND_TICK) && req_ff.env_active;
   assign down_mode = (sweep_start_ff > sweep_target_ff) && (sweep_rate_ff != '0);
   assign c_rd      = cutoff_ff[idx];
   assign c_add     = {1'b0, c_rd} + {{(CUT_W+1-RATE_W){1'b0}}, sweep_rate_ff};

   always_comb begin
      c_up = c_rd;
      if (!down_mode && (c_rd < sweep_target_ff) && (sweep_rate_ff != '0)) begin
         c_up = (c_add > {1'b0, CUTOFF_MAX}) ? CUTOFF_MAX : c_add[CUT_W-1:0];
      end
   end

   assign status.div_go   = tick && down_mode && (c_rd > sweep_target_ff);
   assign status.div_last = (dcnt_ff == DCNT_W'(DIV_BITS - 1));

   assign rem_sh = {rem_ff, quo_ff[DIV_BITS-1]};
   assign q_bit  = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      work_in     = work_ff;
      div_used_in = div_used_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      dcnt_in     = dcnt_ff;
      if (cmd.fetch) begin
         work_in     = c_up;
         div_used_in = status.div_go;
         quo_in      = c_rd * SWEEP_MUL;
         rem_in      = '0;
         dvs_in      = SWEEP_BASE + {{(DVS_W-RATE_W){1'b0}}, sweep_rate_ff};
         dcnt_in     = '0;
      end else if (cmd.div_step) begin
         quo_in  = {quo_ff[DIV_BITS-2:0], q_bit};
         rem_in  = q_bit ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_W-1:0];
         dcnt_in = dcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      div_used_ff <= div_used_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      dcnt_ff     <= dcnt_in;
   end

   // sweep result, then one triangle step
   assign c_sw      = div_used_ff ? quo_ff[CUT_W-1:0] : work_ff;
   assign lfo_on    = (lfo_rate_ff != '0) && (lfo_depth_ff != '0);
   assign step      = (lfo_depth_ff >= 8'd200) ? 2'd2 :
                      (lfo_depth_ff >= 8'd100) ? 2'd1 : 2'd0;
   assign c_step_up = {1'b0, c_sw} + {{(CUT_W-1){1'b0}}, step};
   assign cnt_inc   = count_ff[idx] + 1'b1;
   assign cnt_prod  = cnt_inc * lfo_rate_ff;
   assign flip      = cnt_prod > (CNT_W+RATE_W)'(LFO_SPAN);

   always_comb begin
      c_lfo = c_sw;
      if (lfo_on) begin
         if (down_ff[idx]) begin
            if (c_sw > CUT_W'(step)) c_lfo = c_sw - CUT_W'(step);
         end else begin
            if (c_step_up < {1'b0, CUTOFF_MAX}) c_lfo = c_step_up[CUT_W-1:0];
         end
      end
   end

   always_comb begin
      c_new = c_rd;
      if (req_ff.kind == KIND_RESTART) c_new = sweep_start_ff;
      else if (tick)                   c_new = c_lfo;
      c_out = voice_ok ? c_new : '0;
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.update) begin
         rsp_in.voice_out = req_ff.voice;
         rsp_in.cutoff    = c_out;
         rsp_in.type_out  = filter_type_ff;
         rsp_in.apply     = voice_ok && (c_out <= CUTOFF_MAX) && (filter_type_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VOICES; i++) begin
            cutoff_ff[i] <= '0;
            count_ff[i]  <= '0;
            down_ff[i]   <= 1'b0;
         end
      end else if (cmd.update && voice_ok) begin
         cutoff_ff[idx] <= c_new;
         if (tick && lfo_on) begin
            count_ff[idx] <= flip ? '0 : cnt_inc;
            down_ff[idx]  <= down_ff[idx] ^ flip;
         end
      end
   end

endmodule

FILE: dv/tb_filter_cutoff_sweep_lfo_core.sv
module tb_filter_cutoff_sweep_lfo_core;
   import fcsl_pkg::*;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          DRAIN_TAIL  = 40;
   localparam int          PHASES      = 19;
   localparam int          PHASE_WORDS = 100;
   localparam int          MAX_GAP     = 6;
   localparam int          PRINT_MAX   = 50;
   localparam int unsigned DEPTH_DIV   = 100;

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      req_type               word;
      logic                  chk;
      logic [CUT_W-1:0]      cut;
      logic                  ap;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req;
   logic                  rsp_valid;
   rsp_type               rsp;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   filter_cutoff_sweep_lfo_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [CUT_W-1:0]  cfg_sweep_start;
   logic [CUT_W-1:0]  cfg_sweep_target;
   logic [RATE_W-1:0] cfg_sweep_rate;
   logic [RATE_W-1:0] cfg_lfo_rate;
   logic [RATE_W-1:0] cfg_lfo_depth;
   logic [TYPE_W-1:0] cfg_filter_type;

   logic [CUT_W-1:0]  cutoff_mem [NUM_VOICES];
   logic [CNT_W-1:0]  lfo_cnt    [NUM_VOICES];
   logic              lfo_down   [NUM_VOICES];

   rsp_type           pending_cutoffs [$];
   stim_row_type      directed [$];
   int                mismatches = 0;
   int                cycles = 0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatches < PRINT_MAX) begin
         $display("tb: mismatch %s got %0d want %0d", what, got, want);
      end
      mismatches++;
   endtask

   function automatic rsp_type advance_cutoff(req_type w);
      rsp_type     r;
      int unsigned c;
      int unsigned step;
      r.voice_out = w.voice;
      r.cutoff    = '0;
      r.type_out  = cfg_filter_type;
      r.apply     = 1'b0;
      if (int'(w.voice) < NUM_VOICES) begin
         if (w.kind == KIND_RESTART) begin
            cutoff_mem[w.voice] = cfg_sweep_start;
         end else if (w.env_active) begin
            c = 32'(cutoff_mem[w.voice]);
            if (cfg_sweep_start > cfg_sweep_target && cfg_sweep_rate != 0) begin
               if (c > 32'(cfg_sweep_target)) begin
                  c = c * 32'(SWEEP_MUL) / (32'(SWEEP_BASE) + 32'(cfg_sweep_rate));
               end
            end else if (c < 32'(cfg_sweep_target) && cfg_sweep_rate != 0) begin
               c = c + 32'(cfg_sweep_rate);
               if (c > 32'(CUTOFF_MAX)) c = 32'(CUTOFF_MAX);
            end
            if (cfg_lfo_rate != 0 && cfg_lfo_depth != 0) begin
               step = 32'(cfg_lfo_depth) / DEPTH_DIV;
               if (lfo_down[w.voice]) begin
                  if (c > step) c = c - step;
               end else if (c + step < 32'(CUTOFF_MAX)) begin
                  c = c + step;
               end
               lfo_cnt[w.voice] = lfo_cnt[w.voice] + 1'b1;
               if (32'(lfo_cnt[w.voice]) > 32'(LFO_SPAN) / 32'(cfg_lfo_rate)) begin
                  lfo_cnt[w.voice]  = '0;
                  lfo_down[w.voice] = ~lfo_down[w.voice];
               end
            end
            cutoff_mem[w.voice] = CUT_W'(c);
         end
         r.cutoff = cutoff_mem[w.voice];
         r.apply  = (cutoff_mem[w.voice] <= CUTOFF_MAX) && (cfg_filter_type != 0);
      end
      return r;
   endfunction

   always @(posedge clock) begin : check_words
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_cutoffs.size() == 0) begin
            report_mismatch("word with nothing pending, cutoff", 32'(rsp.cutoff), 0);
         end else begin
            want = pending_cutoffs.pop_front();
            if (rsp.voice_out !== want.voice_out)
               report_mismatch("voice_out", 32'(rsp.voice_out), 32'(want.voice_out));
            if (rsp.cutoff !== want.cutoff)
               report_mismatch("cutoff", 32'(rsp.cutoff), 32'(want.cutoff));
            if (rsp.type_out !== want.type_out)
               report_mismatch("type_out", 32'(rsp.type_out), 32'(want.type_out));
            if (rsp.apply !== want.apply)
               report_mismatch("apply", 32'(rsp.apply), 32'(want.apply));
         end
      end
   end

   task automatic send_word(req_type w, logic chk, logic [CUT_W-1:0] cut, logic ap);
      rsp_type want;
      start <= 1'b1;
      req   <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = advance_cutoff(w);
      if (chk) begin
         want.cutoff = cut;
         want.apply  = ap;
      end
      pending_cutoffs.push_back(want);
   endtask

   task automatic hold_sender(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_cutoffs.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SWEEP_START:  cfg_sweep_start  = data[CUT_W-1:0];
         CSR_SWEEP_TARGET: cfg_sweep_target = data[CUT_W-1:0];
         CSR_SWEEP_RATE:   cfg_sweep_rate   = data[RATE_W-1:0];
         CSR_LFO_RATE:     cfg_lfo_rate     = data[RATE_W-1:0];
         CSR_LFO_DEPTH:    cfg_lfo_depth    = data[RATE_W-1:0];
         CSR_FILTER_TYPE:  cfg_filter_type  = data[TYPE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r        = '0;
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.data   = data;
      return r;
   endfunction

   function automatic stim_row_type word_row(logic kind, int voice, logic env,
                                             logic chk, int cut, logic ap);
      stim_row_type r;
      r                 = '0;
      r.word.kind       = kind;
      r.word.voice      = VOICE_W'(voice);
      r.word.env_active = env;
      r.chk             = chk;
      r.cut             = CUT_W'(cut);
      r.ap              = ap;
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_cutoff();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return CSR_DATA_W'(CUTOFF_MAX);
         3:       return CSR_DATA_W'($urandom_range(14990, 15010));
         4:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(0, 16000));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_rate();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return CSR_DATA_W'(8'hff);
         2:       return CSR_DATA_W'(1);
         default: return CSR_DATA_W'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin : stimulus
      req_type w;
      int      roll;
      int      vmax;
      bit      quiet;
      reset     = 1'b1;
      start     = 1'b0;
      req       = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_sweep_start  = '0;
      cfg_sweep_target = '0;
      cfg_sweep_rate   = '0;
      cfg_lfo_rate     = '0;
      cfg_lfo_depth    = '0;
      cfg_filter_type  = '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
         cutoff_mem[i] = '0;
         lfo_cnt[i]    = '0;
         lfo_down[i]   = 1'b0;
      end

      directed = '{
         word_row(KIND_TICK,    0, 1'b1, 1'b1, 0, 1'b0),
         word_row(KIND_RESTART, 7, 1'b0, 1'b1, 0, 1'b0),
         csr_row(CSR_FILTER_TYPE, 16'd1),
         csr_row(CSR_SWEEP_START, 16'hffff),
         word_row(KIND_RESTART, 1, 1'b1, 1'b1, 65535, 1'b0),
         word_row(KIND_TICK,    1, 1'b0, 1'b1, 65535, 1'b0),
         csr_row(CSR_SWEEP_TARGET, 16'd100),
         csr_row(CSR_SWEEP_RATE, 16'd255),
         word_row(KIND_TICK,    1, 1'b1, 1'b0, 0, 1'b0),
         word_row(KIND_TICK,    1, 1'b1, 1'b0, 0, 1'b0),
         csr_row(CSR_SWEEP_START, 16'd15000),
         word_row(KIND_RESTART, 2, 1'b0, 1'b1, 15000, 1'b1),
         word_row(KIND_TICK,    2, 1'b1, 1'b0, 0, 1'b0),
         csr_row(CSR_FILTER_TYPE, 16'd3),
         csr_row(CSR_SWEEP_START, 16'd0),
         csr_row(CSR_SWEEP_TARGET, 16'hffff),
         word_row(KIND_RESTART, 3, 1'b1, 1'b1, 0, 1'b1),
         word_row(KIND_TICK,    3, 1'b1, 1'b1, 255, 1'b1),
         csr_row(CSR_SWEEP_START, 16'd14900),
         word_row(KIND_RESTART, 4, 1'b0, 1'b1, 14900, 1'b1),
         word_row(KIND_TICK,    4, 1'b1, 1'b1, 15000, 1'b1),
         csr_row(CSR_SWEEP_START, 16'd20000),
         word_row(KIND_RESTART, 5, 1'b0, 1'b1, 20000, 1'b0),
         word_row(KIND_TICK,    5, 1'b1, 1'b1, 15000, 1'b1),
         csr_row(CSR_SWEEP_RATE, 16'd0),
         csr_row(CSR_LFO_RATE, 16'd255),
         csr_row(CSR_LFO_DEPTH, 16'd255),
         csr_row(CSR_FILTER_TYPE, 16'd2),
         csr_row(CSR_SWEEP_START, 16'd14999),
         word_row(KIND_RESTART, 6, 1'b1, 1'b1, 14999, 1'b1),
         word_row(KIND_TICK,    6, 1'b1, 1'b0, 0, 1'b0),
         word_row(KIND_TICK,    6, 1'b1, 1'b0, 0, 1'b0),
         word_row(KIND_TICK,    6, 1'b1, 1'b0, 0, 1'b0),
         word_row(KIND_TICK,    6, 1'b1, 1'b0, 0, 1'b0),
         csr_row(CSR_SWEEP_START, 16'd1),
         word_row(KIND_RESTART, 6, 1'b0, 1'b1, 1, 1'b1),
         word_row(KIND_TICK,    6, 1'b1, 1'b0, 0, 1'b0),
         csr_row(CSR_LFO_DEPTH, 16'd99),
         csr_row(CSR_LFO_RATE, 16'd1),
         word_row(KIND_TICK,    6, 1'b1, 1'b0, 0, 1'b0)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            drain();
            write_csr(directed[i].idx, directed[i].data);
         end else begin
            send_word(directed[i].word, directed[i].chk, directed[i].cut, directed[i].ap);
            hold_sender($urandom_range(0, MAX_GAP));
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_csr(CSR_SWEEP_START, pick_cutoff());
         write_csr(CSR_SWEEP_TARGET, pick_cutoff());
         write_csr(CSR_SWEEP_RATE, pick_rate());
         write_csr(CSR_LFO_RATE, pick_rate());
         write_csr(CSR_LFO_DEPTH, pick_rate());
         write_csr(CSR_FILTER_TYPE, CSR_DATA_W'($urandom_range(0, 3)));
         vmax  = ($urandom_range(0, 2) == 0) ? 1 : NUM_VOICES - 1;
         quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            roll         = $urandom_range(0, 99);
            w.voice      = VOICE_W'($urandom_range(0, vmax));
            w.kind       = (roll < 10) ? KIND_RESTART : KIND_TICK;
            w.env_active = (roll < 10) ? 1'($urandom_range(0, 1)) : (roll >= 20);
            send_word(w, 1'b0, '0, 1'b0);
            hold_sender(quiet ? 0 : $urandom_range(0, MAX_GAP));
         end
      end

      drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
